// ===== hw/rtl/bitmap_block_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator checker.
// Used by bba_checker.sv; needs nothing else.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Consequent in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap block allocator check failed");

// Consequent in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");

`endif

// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by every other file of the block except the macro header.
`default_nettype none

package bba_pkg;

  localparam int WORD_W     = 64;  // bitmap bits per memory word
  localparam int BIT_W      = 6;   // bit select inside one word
  localparam int NUM_W      = 21;  // block or inode number
  localparam int BASE_W     = 20;  // pool base register
  localparam int BYTES_W    = 10;  // map_bytes register
  localparam int BYTE_SHIFT = 3;   // bits per byte as a shift
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 20;
  localparam int STAT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BYTES  = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] onehot;
  } bba_find_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_word_find.sv =====
// Lowest-clear-bit search over one bitmap word.
// Depends on bba_pkg.
`default_nettype none

module bba_word_find (
  input  wire logic [bba_pkg::WORD_W-1:0] rd_word,
  input  wire logic [bba_pkg::WORD_W-1:0] beyond_mask,
  output bba_pkg::bba_find_t              find
);

  logic [bba_pkg::WORD_W-1:0] free_bits;
  logic [bba_pkg::WORD_W-1:0] lowest;
  logic [bba_pkg::BIT_W-1:0]  enc;

  // Bits past the limit count as taken.
  assign free_bits = ~(rd_word | beyond_mask);
  assign lowest    = free_bits & (~free_bits + bba_pkg::WORD_W'(1));

  always_comb begin
    enc = '0;
    for (int k = 0; k < bba_pkg::WORD_W; k++) begin
      enc = enc | (lowest[k] ? bba_pkg::BIT_W'(k) : '0);
    end
  end

  assign find.found   = |free_bits;
  assign find.bit_idx = enc;
  assign find.onehot  = lowest;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// First-fit allocator over two bitmaps (data blocks, inodes) held in one memory.
// Depends on bba_pkg and bba_word_find.
`default_nettype none

// After reset the block sweeps its whole bitmap memory, both pools, to zero,
// one word per cycle, with busy high. A request is taken when start is high
// and busy is low. Its result shows on the out_ ports for one cycle with
// out_valid, and the receiver cannot stall it. A free checks the range in
// S_FCHK (ST_RANGE if out of range) and reads the word, then clears the bit
// in S_FWR. An allocate scans the pool's words in use from word 0 in S_SCAN,
// sets the lowest clear bit of the first word that has one and reports the
// number from S_FIN, or reports ST_FULL after the last word; with no bits in
// use it reports ST_FULL straight from idle. The bitmap memory port reads one
// 64-bit word per cycle during the scan. A new request may be taken in the
// cycle the previous result is shown.
module bitmap_block_allocator #(
  parameter int MAP_BITS = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic                           in_func,
  input  wire logic                           in_pool,
  input  wire logic [bba_pkg::NUM_W-1:0]      in_item_number,
  output      logic                           out_valid,
  output      logic [bba_pkg::NUM_W-1:0]      out_alloc_number,
  output      logic [bba_pkg::STAT_W-1:0]     out_status,
  input  wire logic                           cfg_we,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int WORD_W    = bba_pkg::WORD_W;
  localparam int BIT_W     = bba_pkg::BIT_W;
  localparam int NUM_W     = bba_pkg::NUM_W;
  localparam int WORDS     = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MA_W      = WA_W + 1;
  localparam int MEM_DEPTH = 2 ** MA_W;
  localparam int LIM_W     = $clog2(MAP_BITS + 1);
  localparam int B8_W      = bba_pkg::BYTES_W + bba_pkg::BYTE_SHIFT;
  localparam int CNT_W     = (LIM_W > B8_W) ? LIM_W : B8_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_FWR   = 3'd5;

  logic [2:0]                     st_r, st_nxt;
  logic [MA_W-1:0]                clr_r, clr_nxt;
  logic                           pool_r, pool_nxt;
  logic [NUM_W-1:0]               item_r, item_nxt;
  logic [WA_W-1:0]                chk_r, chk_nxt;
  logic [CNT_W-1:0]               gidx_r, gidx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]               out_num_r, out_num_nxt;
  logic [bba_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;

  logic [bba_pkg::BASE_W-1:0]     data_base_r, inode_base_r;
  logic [bba_pkg::BYTES_W-1:0]    map_bytes_r;

  logic [WORD_W-1:0]              mem [MEM_DEPTH];
  logic [WORD_W-1:0]              rdata_r;
  logic                           rd_en, wr_en;
  logic [MA_W-1:0]                rd_addr, wr_addr;
  logic [WORD_W-1:0]              wr_data;

  logic [CNT_W-1:0]               bytes8, lim, part_w;
  logic [WA_W-1:0]                last_w;
  logic [WORD_W-1:0]              beyond;
  logic [bba_pkg::BASE_W-1:0]     base_sel;
  logic [NUM_W-1:0]               diff;
  logic                           below, over;
  logic                           accept;
  bba_pkg::bba_find_t             find;

  // Bits in use, capped at the map size.
  assign bytes8 = CNT_W'({map_bytes_r, {bba_pkg::BYTE_SHIFT{1'b0}}});
  assign lim    = (bytes8 > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : bytes8;
  assign last_w = WA_W'((lim - CNT_W'(1)) >> BIT_W);
  assign part_w = lim >> BIT_W;
  assign beyond = (CNT_W'(chk_r) == part_w)
                ? ~((WORD_W'(1) << lim[BIT_W-1:0]) - WORD_W'(1)) : '0;

  assign base_sel = pool_r ? inode_base_r : data_base_r;
  assign below    = item_r <= NUM_W'(base_sel);
  assign diff     = item_r - NUM_W'(base_sel) - NUM_W'(1);
  assign over     = diff >= NUM_W'(lim);

  assign busy   = st_r != S_IDLE;
  assign accept = start && !busy;

  bba_word_find u_find (
    .rd_word     (rdata_r),
    .beyond_mask (beyond),
    .find        (find)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    st_nxt         = st_r;
    clr_nxt        = clr_r;
    pool_nxt       = pool_r;
    item_nxt       = item_r;
    chk_nxt        = chk_r;
    gidx_nxt       = gidx_r;
    out_valid_nxt  = 1'b0;
    out_num_nxt    = out_num_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    unique case (st_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + MA_W'(1);
        if (clr_r == MA_W'(MEM_DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pool_nxt = in_pool;
          item_nxt = in_item_number;
          if (in_func == bba_pkg::FUNC_ALLOC) begin
            if (lim == '0) begin
              out_valid_nxt  = 1'b1;
              out_num_nxt    = '0;
              out_status_nxt = bba_pkg::ST_FULL;
            end else begin
              rd_en   = 1'b1;
              rd_addr = {in_pool, WA_W'(0)};
              chk_nxt = '0;
              st_nxt  = S_SCAN;
            end
          end else begin
            st_nxt = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (find.found) begin
          wr_en    = 1'b1;
          wr_addr  = {pool_r, chk_r};
          wr_data  = rdata_r | find.onehot;
          gidx_nxt = CNT_W'({chk_r, find.bit_idx});
          st_nxt   = S_FIN;
        end else if (chk_r == last_w) begin
          out_valid_nxt  = 1'b1;
          out_num_nxt    = '0;
          out_status_nxt = bba_pkg::ST_FULL;
          st_nxt         = S_IDLE;
        end else begin
          // Fetch the next word; its data is checked next cycle.
          chk_nxt = chk_r + WA_W'(1);
          rd_en   = 1'b1;
          rd_addr = {pool_r, chk_r + WA_W'(1)};
        end
      end
      S_FIN: begin
        out_valid_nxt  = 1'b1;
        out_num_nxt    = NUM_W'(base_sel) + NUM_W'(gidx_r) + NUM_W'(1);
        out_status_nxt = bba_pkg::ST_OK;
        st_nxt         = S_IDLE;
      end
      S_FCHK: begin
        if (below || over) begin
          out_valid_nxt  = 1'b1;
          out_num_nxt    = '0;
          out_status_nxt = bba_pkg::ST_RANGE;
          st_nxt         = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = {pool_r, WA_W'(diff >> BIT_W)};
          gidx_nxt = CNT_W'(diff);
          st_nxt   = S_FWR;
        end
      end
      S_FWR: begin
        wr_en          = 1'b1;
        wr_addr        = {pool_r, WA_W'(gidx_r >> BIT_W)};
        wr_data        = rdata_r & ~(WORD_W'(1) << gidx_r[BIT_W-1:0]);
        out_valid_nxt  = 1'b1;
        out_num_nxt    = '0;
        out_status_nxt = bba_pkg::ST_OK;
        st_nxt         = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pool_r       <= pool_nxt;
    item_r       <= item_nxt;
    chk_r        <= chk_nxt;
    gidx_r       <= gidx_nxt;
    out_num_r    <= out_num_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r  <= '0;
      inode_base_r <= '0;
      map_bytes_r  <= bba_pkg::BYTES_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bba_pkg::CFG_DATA_BASE:  data_base_r  <= cfg_wdata;
        bba_pkg::CFG_INODE_BASE: inode_base_r <= cfg_wdata;
        bba_pkg::CFG_MAP_BYTES:  map_bytes_r  <= cfg_wdata[bba_pkg::BYTES_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_alloc_number = out_num_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_checker.sv =====
// Port-level checks of the bitmap block allocator, bound to its top level.
// Depends on bba_pkg and bitmap_block_allocator_macros.svh.
`default_nettype none

`include "bitmap_block_allocator_macros.svh"

module bba_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic [bba_pkg::NUM_W-1:0]  out_alloc_number,
  input wire logic [bba_pkg::STAT_W-1:0] out_status
);

  // A transfer starts work or yields a result at once.
  `BBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy || out_valid)
  // A strobe repeats only when a new request is taken in its cycle.
  `BBA_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid && !start, !out_valid)
  // Results appear only once the block is ready again.
  `BBA_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid, !busy)
  // Failed requests carry no number.
  `BBA_ASSERT_SAME(a_fail_zero, clk, rst_n,
    out_valid && out_status != bba_pkg::ST_OK, out_alloc_number == '0)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_alloc_number (out_alloc_number),
  .out_status       (out_status)
);

`default_nettype wire
